// ===== hdl/ps2kbd_pkg.sv =====
`timescale 1ns / 1ps
package ps2kbd_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] scancode;
    } in_word_t;

    typedef struct packed {
        logic       produced;
        logic [7:0] symbol;
        logic [2:0] special_key;
        logic [3:0] modifiers;
        logic       ctrl_c_raised;
        logic       event_dropped;
        logic [6:0] pending_events;
    } out_word_t;

    typedef struct packed {
        logic [3:0] modifiers;
        logic [2:0] special_key;
        logic [7:0] symbol;
    } event_t;

    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_RELEASE   = 8'h80;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CTRL      = 7'h1D;
    localparam logic [6:0] SC_ALT       = 7'h38;
    localparam logic [6:0] SC_CAPS      = 7'h3A;
    localparam logic [7:0] SYM_CTRL_C   = 8'h03;
    localparam logic       ACT_SCANCODE = 1'b0;
    localparam logic       ACT_READ     = 1'b1;
    localparam logic [1:0] REG_LAYOUT   = 2'd0;

    function automatic logic [7:0] map_us_normal(input logic [6:0] i);
        case (i)
            7'h01: return 8'd27;  7'h02: return "1"; 7'h03: return "2"; 7'h04: return "3";
            7'h05: return "4"; 7'h06: return "5"; 7'h07: return "6"; 7'h08: return "7";
            7'h09: return "8"; 7'h0A: return "9"; 7'h0B: return "0"; 7'h0C: return "-";
            7'h0D: return "="; 7'h0E: return 8'd8; 7'h0F: return 8'd9;
            7'h10: return "q"; 7'h11: return "w"; 7'h12: return "e"; 7'h13: return "r";
            7'h14: return "t"; 7'h15: return "y"; 7'h16: return "u"; 7'h17: return "i";
            7'h18: return "o"; 7'h19: return "p"; 7'h1A: return "["; 7'h1B: return "]";
            7'h1C: return 8'd10; 7'h1E: return "a"; 7'h1F: return "s";
            7'h20: return "d"; 7'h21: return "f"; 7'h22: return "g"; 7'h23: return "h";
            7'h24: return "j"; 7'h25: return "k"; 7'h26: return "l"; 7'h27: return ";";
            7'h28: return 8'h27; 7'h29: return 8'h60; 7'h2B: return 8'h5C;
            7'h2C: return "z"; 7'h2D: return "x"; 7'h2E: return "c"; 7'h2F: return "v";
            7'h30: return "b"; 7'h31: return "n"; 7'h32: return "m"; 7'h33: return ",";
            7'h34: return "."; 7'h35: return "/"; 7'h37: return "*"; 7'h39: return " ";
            7'h47: return "7"; 7'h48: return "8"; 7'h49: return "9"; 7'h4A: return "-";
            7'h4B: return "4"; 7'h4C: return "5"; 7'h4D: return "6"; 7'h4E: return "+";
            7'h4F: return "1"; 7'h50: return "2"; 7'h51: return "3"; 7'h52: return "0";
            7'h53: return ".";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] map_us_shift(input logic [6:0] i);
        case (i)
            7'h01: return 8'd27;  7'h02: return "!"; 7'h03: return "@"; 7'h04: return "#";
            7'h05: return "$"; 7'h06: return "%"; 7'h07: return "^"; 7'h08: return "&";
            7'h09: return "*"; 7'h0A: return "("; 7'h0B: return ")"; 7'h0C: return "_";
            7'h0D: return "+"; 7'h0E: return 8'd8; 7'h0F: return 8'd9;
            7'h10: return "Q"; 7'h11: return "W"; 7'h12: return "E"; 7'h13: return "R";
            7'h14: return "T"; 7'h15: return "Y"; 7'h16: return "U"; 7'h17: return "I";
            7'h18: return "O"; 7'h19: return "P"; 7'h1A: return "{"; 7'h1B: return "}";
            7'h1C: return 8'd10; 7'h1E: return "A"; 7'h1F: return "S";
            7'h20: return "D"; 7'h21: return "F"; 7'h22: return "G"; 7'h23: return "H";
            7'h24: return "J"; 7'h25: return "K"; 7'h26: return "L"; 7'h27: return ":";
            7'h28: return 8'h22; 7'h29: return "~"; 7'h2B: return "|";
            7'h2C: return "Z"; 7'h2D: return "X"; 7'h2E: return "C"; 7'h2F: return "V";
            7'h30: return "B"; 7'h31: return "N"; 7'h32: return "M"; 7'h33: return "<";
            7'h34: return ">"; 7'h35: return "?"; 7'h37: return "*"; 7'h39: return " ";
            7'h47: return "7"; 7'h48: return "8"; 7'h49: return "9"; 7'h4A: return "-";
            7'h4B: return "4"; 7'h4C: return "5"; 7'h4D: return "6"; 7'h4E: return "+";
            7'h4F: return "1"; 7'h50: return "2"; 7'h51: return "3"; 7'h52: return "0";
            7'h53: return ".";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] map_de_normal(input logic [6:0] i);
        case (i)
            7'h01: return 8'd27;  7'h02: return "1"; 7'h03: return "2"; 7'h04: return "3";
            7'h05: return "4"; 7'h06: return "5"; 7'h07: return "6"; 7'h08: return "7";
            7'h09: return "8"; 7'h0A: return "9"; 7'h0B: return "0"; 7'h0C: return 8'hDF;
            7'h0D: return 8'hB4; 7'h0E: return 8'd8; 7'h0F: return 8'd9;
            7'h10: return "q"; 7'h11: return "w"; 7'h12: return "e"; 7'h13: return "r";
            7'h14: return "t"; 7'h15: return "z"; 7'h16: return "u"; 7'h17: return "i";
            7'h18: return "o"; 7'h19: return "p"; 7'h1A: return 8'hFC; 7'h1B: return "+";
            7'h1C: return 8'd10; 7'h1E: return "a"; 7'h1F: return "s";
            7'h20: return "d"; 7'h21: return "f"; 7'h22: return "g"; 7'h23: return "h";
            7'h24: return "j"; 7'h25: return "k"; 7'h26: return "l"; 7'h27: return 8'hF6;
            7'h28: return 8'hE4; 7'h29: return "^"; 7'h2B: return "#";
            7'h2C: return "y"; 7'h2D: return "x"; 7'h2E: return "c"; 7'h2F: return "v";
            7'h30: return "b"; 7'h31: return "n"; 7'h32: return "m"; 7'h33: return ",";
            7'h34: return "."; 7'h35: return "-"; 7'h37: return "*"; 7'h39: return " ";
            7'h47: return "7"; 7'h48: return "8"; 7'h49: return "9"; 7'h4A: return "-";
            7'h4B: return "4"; 7'h4C: return "5"; 7'h4D: return "6"; 7'h4E: return "+";
            7'h4F: return "1"; 7'h50: return "2"; 7'h51: return "3"; 7'h52: return "0";
            7'h53: return ","; 7'h56: return "<";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] map_de_shift(input logic [6:0] i);
        case (i)
            7'h01: return 8'd27;  7'h02: return "!"; 7'h03: return 8'h22; 7'h04: return 8'hA7;
            7'h05: return "$"; 7'h06: return "%"; 7'h07: return "&"; 7'h08: return "/";
            7'h09: return "("; 7'h0A: return ")"; 7'h0B: return "="; 7'h0C: return "?";
            7'h0D: return 8'h60; 7'h0E: return 8'd8; 7'h0F: return 8'd9;
            7'h10: return "Q"; 7'h11: return "W"; 7'h12: return "E"; 7'h13: return "R";
            7'h14: return "T"; 7'h15: return "Z"; 7'h16: return "U"; 7'h17: return "I";
            7'h18: return "O"; 7'h19: return "P"; 7'h1A: return 8'hDC; 7'h1B: return "*";
            7'h1C: return 8'd10; 7'h1E: return "A"; 7'h1F: return "S";
            7'h20: return "D"; 7'h21: return "F"; 7'h22: return "G"; 7'h23: return "H";
            7'h24: return "J"; 7'h25: return "K"; 7'h26: return "L"; 7'h27: return 8'hD6;
            7'h28: return 8'hC4; 7'h29: return 8'hB0; 7'h2B: return 8'h27;
            7'h2C: return "Y"; 7'h2D: return "X"; 7'h2E: return "C"; 7'h2F: return "V";
            7'h30: return "B"; 7'h31: return "N"; 7'h32: return "M"; 7'h33: return ";";
            7'h34: return ":"; 7'h35: return "_"; 7'h37: return "*"; 7'h39: return " ";
            7'h47: return "7"; 7'h48: return "8"; 7'h49: return "9"; 7'h4A: return "-";
            7'h4B: return "4"; 7'h4C: return "5"; 7'h4D: return "6"; 7'h4E: return "+";
            7'h4F: return "1"; 7'h50: return "2"; 7'h51: return "3"; 7'h52: return "0";
            7'h53: return ","; 7'h56: return ">";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] map_de_altgr(input logic [6:0] i);
        case (i)
            7'h03: return 8'hB2; 7'h04: return 8'hB3; 7'h08: return "{"; 7'h09: return "[";
            7'h0A: return "]"; 7'h0B: return "}"; 7'h0C: return 8'h5C; 7'h10: return "@";
            7'h12: return 8'h80; 7'h1B: return "~"; 7'h32: return 8'hB5; 7'h56: return "|";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic is_ascii_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic letter_or_umlaut(input logic [7:0] c);
        return is_ascii_letter(c) || c == 8'hE4 || c == 8'hC4 || c == 8'hF6 ||
               c == 8'hD6 || c == 8'hFC || c == 8'hDC;
    endfunction

    function automatic logic [2:0] special_code(input logic [7:0] sc);
        case (sc)
            8'h48: return 3'd1;
            8'h50: return 3'd2;
            8'h4B: return 3'd3;
            8'h4D: return 3'd4;
            8'h53: return 3'd5;
            8'h47: return 3'd6;
            8'h4F: return 3'd7;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// ===== hdl/ps2kbd_decoder.sv =====
`timescale 1ns / 1ps
module ps2kbd_decoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            scancode,
    input  logic                  layout,
    output logic                  key_valid,
    output ps2kbd_pkg::event_t    key_event,
    output logic [3:0]            live_mods
);

    logic lshift_reg, rshift_reg, lctrl_reg, rctrl_reg, caps_reg, altgr_reg, prefix_reg;
    logic lshift_next, rshift_next, lctrl_next, rctrl_next, caps_next, altgr_next;
    logic prefix_next;
    logic [6:0] make;
    logic [7:0] normal, shifted, alt, chr;
    logic       use_shift;
    logic [7:0] sym;
    logic [2:0] spec;

    assign make = scancode[6:0];

    always_comb
    begin
        normal  = layout ? ps2kbd_pkg::map_de_normal(make) : ps2kbd_pkg::map_us_normal(make);
        shifted = layout ? ps2kbd_pkg::map_de_shift(make) : ps2kbd_pkg::map_us_shift(make);
        alt     = layout ? ps2kbd_pkg::map_de_altgr(make) : 8'd0;
        use_shift = lshift_reg | rshift_reg;
        if (caps_reg && ps2kbd_pkg::letter_or_umlaut(normal))
        begin
            use_shift = ~use_shift;
        end
        if (altgr_reg && alt != 8'd0)
        begin
            chr = alt;
        end
        else if (use_shift && shifted != 8'd0)
        begin
            chr = shifted;
        end
        else
        begin
            chr = normal;
        end
        if ((lctrl_reg | rctrl_reg) && ps2kbd_pkg::is_ascii_letter(chr))
        begin
            chr = {3'b000, chr[4:0]};
        end
    end

    always_comb
    begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        lctrl_next  = lctrl_reg;
        rctrl_next  = rctrl_reg;
        caps_next   = caps_reg;
        altgr_next  = altgr_reg;
        prefix_next = 1'b0;
        sym         = 8'd0;
        spec        = 3'd0;
        if (scancode == ps2kbd_pkg::SC_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else if (scancode[7])
        begin
            if (make == ps2kbd_pkg::SC_LSHIFT)
                lshift_next = 1'b0;
            else if (make == ps2kbd_pkg::SC_RSHIFT)
                rshift_next = 1'b0;
            else if (make == ps2kbd_pkg::SC_ALT && prefix_reg)
                altgr_next = 1'b0;
            else if (make == ps2kbd_pkg::SC_CTRL)
            begin
                if (prefix_reg)
                    rctrl_next = 1'b0;
                else
                    lctrl_next = 1'b0;
            end
        end
        else if (prefix_reg)
        begin
            if (make == ps2kbd_pkg::SC_ALT)
                altgr_next = 1'b1;
            else if (make == ps2kbd_pkg::SC_CTRL)
                rctrl_next = 1'b1;
            else
                spec = ps2kbd_pkg::special_code(scancode);
        end
        else if (make == ps2kbd_pkg::SC_LSHIFT)
            lshift_next = 1'b1;
        else if (make == ps2kbd_pkg::SC_RSHIFT)
            rshift_next = 1'b1;
        else if (make == ps2kbd_pkg::SC_CTRL)
            lctrl_next = 1'b1;
        else if (make == ps2kbd_pkg::SC_CAPS)
            caps_next = ~caps_reg;
        else if (make != ps2kbd_pkg::SC_ALT)
            sym = chr;
    end

    assign live_mods = {caps_next, altgr_next, lctrl_next | rctrl_next,
                        lshift_next | rshift_next};
    assign key_valid = (sym != 8'd0) || (spec != 3'd0);
    assign key_event = '{modifiers: live_mods, special_key: spec, symbol: sym};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            lctrl_reg  <= 1'b0;
            rctrl_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            altgr_reg  <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else if (step)
        begin
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            lctrl_reg  <= lctrl_next;
            rctrl_reg  <= rctrl_next;
            caps_reg   <= caps_next;
            altgr_reg  <= altgr_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ===== hdl/ps2kbd_queue.sv =====
`timescale 1ns / 1ps
module ps2kbd_queue
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ps2kbd_pkg::event_t    push_data,
    input  logic                  pop,
    output logic                  pop_ok,
    output logic                  dropped,
    output logic [6:0]            count_out,
    output ps2kbd_pkg::event_t    rd_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    ps2kbd_pkg::event_t mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg, rd_next, wr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // The head entry is read at the pop edge and the read register then holds it
    // until the next pop, so the result stays put while the output is stalled.
    always_comb
    begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        cnt_next = cnt_reg;
        pop_ok   = 1'b0;
        dropped  = 1'b0;
        if (pop)
        begin
            if (cnt_reg != '0)
            begin
                pop_ok   = 1'b1;
                rd_next  = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (push)
        begin
            if (cnt_reg == FULL)
            begin
                dropped = 1'b1;
                rd_next = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        end
    end

    assign count_out = 7'(cnt_next);

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            mem[wr_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data <= mem[rd_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/ps2_scancode_to_key_events.sv =====
`timescale 1ns / 1ps
// Each word passes through an accept cycle that updates the decoder and queue
// pointers and reads a popped entry into the memory's read register, then a settle cycle.
// The result is offered after the settle cycle; a new word is not taken before then, nor
// while a result is stalled, because the event memory has a registered read.
// Reset (rst_n, asynchronous) clears modifiers, prefix, queue pointers and count and
// sets the layout to German; the event memory itself is not cleared.
module ps2_scancode_to_key_events
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ps2kbd_pkg::in_word_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ps2kbd_pkg::out_word_t  out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic layout_reg;
    logic busy_reg;
    logic acc;
    logic key_valid;
    ps2kbd_pkg::event_t key_event, rd_data;
    logic [3:0] live_mods;
    logic pop_ok, dropped;
    logic [6:0] cnt;
    logic is_read;
    logic pend_pop_reg;
    ps2kbd_pkg::out_word_t hold_reg;
    logic hold_valid_reg;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, layout_reg};
    assign in_stall = busy_reg | (out_valid & out_stall);
    assign acc      = in_valid & ~in_stall;
    assign is_read  = (in_data.action == ps2kbd_pkg::ACT_READ);

    ps2kbd_decoder u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (acc & ~is_read),
        .scancode  (in_data.scancode),
        .layout    (layout_reg),
        .key_valid (key_valid),
        .key_event (key_event),
        .live_mods (live_mods)
    );

    ps2kbd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc & ~is_read & key_valid),
        .push_data (key_event),
        .pop       (acc & is_read),
        .pop_ok    (pop_ok),
        .dropped   (dropped),
        .count_out (cnt),
        .rd_data   (rd_data)
    );

    // out_valid is raised after the settle cycle; rd_data holds the popped word.
    assign out_valid = hold_valid_reg & ~busy_reg;
    always_comb
    begin
        out_data = hold_reg;
        if (pend_pop_reg)
        begin
            out_data.symbol      = rd_data.symbol;
            out_data.special_key = rd_data.special_key;
            out_data.modifiers   = rd_data.modifiers;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg     <= 1'b1;
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            pend_pop_reg   <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == ps2kbd_pkg::REG_LAYOUT)
            begin
                layout_reg <= pwdata[0];
            end
            busy_reg <= acc;
            if (acc)
            begin
                hold_valid_reg <= 1'b1;
                pend_pop_reg   <= is_read & pop_ok;
            end
            else if (out_valid && !out_stall)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            hold_reg.produced       <= is_read ? pop_ok : key_valid;
            hold_reg.symbol         <= is_read ? 8'd0 : key_event.symbol;
            hold_reg.special_key    <= is_read ? 3'd0 : key_event.special_key;
            hold_reg.modifiers      <= is_read ? 4'd0 : live_mods;
            hold_reg.ctrl_c_raised  <= ~is_read & key_valid &
                                       (key_event.symbol == ps2kbd_pkg::SYM_CTRL_C);
            hold_reg.event_dropped  <= ~is_read & key_valid & dropped;
            hold_reg.pending_events <= cnt;
        end
    end

endmodule

// ===== hdl/ps2kbd_checker.sv =====
`timescale 1ns / 1ps
module ps2kbd_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input ps2kbd_pkg::out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("word accepted in back-to-back cycles");

    a_ctrlc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ctrl_c_raised |-> out_data.produced &&
        out_data.symbol == ps2kbd_pkg::SYM_CTRL_C)
        else $error("ctrl-c flag without ctrl-c symbol");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_dropped |-> out_data.produced)
        else $error("drop reported without a produced key");

endmodule

bind ps2_scancode_to_key_events ps2kbd_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
